>>> rtl/core/dxt1_pkg.sv
// ----------------------------------------------------------------------------
// dxt1_pkg
// Shared types, register indexes and colour arithmetic for the DXT1 decoder.
// ----------------------------------------------------------------------------
package dxt1_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int TEXEL_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 8'd1;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 9'd32;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 9'd32;

    // reciprocals scaled by 2^20, rounded up so the floor stays exact
    localparam logic [15:0] RECIP_31 = 16'd33826;
    localparam logic [15:0] RECIP_63 = 16'd16645;
    // reciprocal of 3 scaled by 2^11, exact for sums below 2047
    localparam logic [9:0]  RECIP_3  = 10'd683;

    // expanded endpoint colours and palette mode of one block
    typedef struct packed {
        logic [7:0] r0;
        logic [7:0] g0;
        logic [7:0] b0;
        logic [7:0] r1;
        logic [7:0] g1;
        logic [7:0] b1;
        logic       four_colour;
    } endpoints_t;

    typedef logic [3:0][TEXEL_W-1:0] texel_row_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [12:0] scaled;
        logic [28:0] prod;
        scaled = 13'(v) * 13'd255;
        prod   = 29'(scaled) * 29'(RECIP_31);
        return prod[27:20];
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [13:0] scaled;
        logic [28:0] prod;
        scaled = 14'(v) * 14'd255;
        prod   = 29'(scaled) * 29'(RECIP_63);
        return prod[27:20];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'(RECIP_3);
        return prod[18:11];
    endfunction

    function automatic endpoints_t unpack_block(input logic [31:0] colours);
        endpoints_t ep;
        logic [15:0] c0;
        logic [15:0] c1;
        c0 = colours[15:0];
        c1 = colours[31:16];
        ep.r0 = expand5(c0[15:11]);
        ep.g0 = expand6(c0[10:5]);
        ep.b0 = expand5(c0[4:0]);
        ep.r1 = expand5(c1[15:11]);
        ep.g1 = expand6(c1[10:5]);
        ep.b1 = expand5(c1[4:0]);
        ep.four_colour = (c0 > c1);
        return ep;
    endfunction

endpackage

>>> rtl/core/dxt1_block_decoder_top.sv
// ----------------------------------------------------------------------------
// dxt1_block_decoder_top
// DXT1 block decoder producing one row of four RGBA texels per transfer.
// ----------------------------------------------------------------------------
// usage
//   s_* : one 64-bit DXT1 block per transfer, colour0 in the low 16 bits
//   m_* : four transfers per block, top texel row first; tdata carries the
//         four texels, the row number and the block column and row; tlast
//         marks the fourth row, tuser the fourth row of the image's last block
//   cfg_* : register writes (0 width, 1 height in blocks), only while idle;
//           other indexes are ignored, cfg_ready is always high
// timing
//   a block is held in the input register while its rows are produced, one
//   per cycle unless m_tready stalls, into the output register; a block passes
//   the input register and its first row then the output register. Block
//   intake is limited by the single output row per cycle; the next block is
//   taken in the cycle that moves out its fourth row, so rows run without gaps.
// reset
//   raster position returns to column 0, row 0; both sizes return to 32
// stall
//   when m_tready is low the output row holds and the input stalls until
//   the held block has handed over its last row
// ----------------------------------------------------------------------------
module dxt1_block_decoder_top
#(
    parameter int COUNTER_BITS = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,   // block_data
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // texel_a, texel_b, texel_c, texel_d, row_in_block, block_col, block_row
    output logic [151:0]                       m_tdata,
    output logic                               m_tlast,   // last_of_block
    output logic                               m_tuser,   // last_of_image
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dxt1_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dxt1_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dxt1_pkg::*;

    localparam int CMPW = (COUNTER_BITS + 1 > CFG_DATA_W) ? COUNTER_BITS + 1 : CFG_DATA_W;
    localparam logic [CMPW-1:0] SPAN = CMPW'(1) << COUNTER_BITS;

    logic [CFG_DATA_W-1:0]   width_reg, height_reg;
    logic [COUNTER_BITS-1:0] col_cnt_reg, col_cnt_next;
    logic [COUNTER_BITS-1:0] row_cnt_reg, row_cnt_next;

    logic        hold_valid_reg, hold_valid_next;
    logic [1:0]  hold_row_reg, hold_row_next;
    endpoints_t  hold_ep_reg;
    logic [31:0] hold_idx_reg;
    logic [7:0]  hold_col_reg, hold_brow_reg;
    logic        hold_img_last_reg;

    logic        out_valid_reg, out_valid_next;
    logic [151:0] out_data_reg;
    logic        out_last_reg, out_user_reg;

    logic [CMPW-1:0] col_ext, row_ext, width_lim, height_lim;
    logic            col_last, row_last;
    logic            accept, out_load, last_row;
    texel_row_t      texels;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == REG_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // raster position and wrap detection
    always_comb
    begin
        col_ext = CMPW'(col_cnt_reg);
        row_ext = CMPW'(row_cnt_reg);
        if (width_reg == '0 || CMPW'(width_reg) > SPAN)
            width_lim = SPAN;
        else
            width_lim = CMPW'(width_reg);
        if (height_reg == '0 || CMPW'(height_reg) > SPAN)
            height_lim = SPAN;
        else
            height_lim = CMPW'(height_reg);
        col_last = (col_ext + CMPW'(1)) >= width_lim;
        row_last = (row_ext + CMPW'(1)) >= height_lim;

        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept)
        begin
            if (col_last)
            begin
                col_cnt_next = '0;
                row_cnt_next = row_last ? '0 : row_cnt_reg + COUNTER_BITS'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COUNTER_BITS'(1);
            end
        end
    end

    // handshake control
    always_comb
    begin
        last_row = (hold_row_reg == 2'd3);
        out_load = hold_valid_reg && (!out_valid_reg || m_tready);
        s_tready = !hold_valid_reg || (out_load && last_row);
        accept   = s_tvalid && s_tready;

        hold_valid_next = hold_valid_reg;
        hold_row_next   = hold_row_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
            hold_row_next   = 2'd0;
        end
        else if (out_load)
        begin
            hold_row_next = hold_row_reg + 2'd1;
            if (last_row)
                hold_valid_next = 1'b0;
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            hold_row_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            col_cnt_reg    <= col_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            hold_valid_reg <= hold_valid_next;
            hold_row_reg   <= hold_row_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // endpoint expansion happens on the way into the input register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_ep_reg       <= unpack_block(s_tdata[31:0]);
            hold_idx_reg      <= s_tdata[63:32];
            hold_col_reg      <= col_ext[7:0];
            hold_brow_reg     <= row_ext[7:0];
            hold_img_last_reg <= col_last && row_last;
        end
    end

    dxt1_row_decode u_row_decode
    (
        .ep      (hold_ep_reg),
        .row_idx (hold_idx_reg[8*hold_row_reg +: 8]),
        .texels  (texels)
    );

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {6'b0, hold_brow_reg, hold_col_reg, hold_row_reg,
                             texels[3], texels[2], texels[1], texels[0]};
            out_last_reg <= last_row;
            out_user_reg <= last_row && hold_img_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    a_accept_starts_row0: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> hold_valid_reg && hold_row_reg == 2'd0)
        else $error("accepted block not held at row 0");

    a_last_is_row3: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[129:128] == 2'd3)
        else $error("tlast on a row other than the fourth");

    a_image_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("image end flagged away from block end");

    a_block_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && !last_row |=> hold_valid_reg && (last_row || !s_tready))
        else $error("block released before its fourth row");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata[129:128]))
        else $error("stalled row changed");

endmodule

>>> rtl/core/dxt1_row_decode.sv
// ----------------------------------------------------------------------------
// dxt1_row_decode
// Builds the four-entry palette and looks up one row of four texels.
// ----------------------------------------------------------------------------
module dxt1_row_decode
(
    input  dxt1_pkg::endpoints_t ep,
    input  logic [7:0]           row_idx,
    output dxt1_pkg::texel_row_t texels
);
    import dxt1_pkg::*;

    logic [7:0]         third_r0, third_g0, third_b0;
    logic [7:0]         third_r1, third_g1, third_b1;
    logic [8:0]         sum_r, sum_g, sum_b;
    logic [TEXEL_W-1:0] pal [4];

    always_comb
    begin
        third_r0 = div3({1'b0, ep.r0, 1'b0} + {2'b0, ep.r1});
        third_g0 = div3({1'b0, ep.g0, 1'b0} + {2'b0, ep.g1});
        third_b0 = div3({1'b0, ep.b0, 1'b0} + {2'b0, ep.b1});
        third_r1 = div3({2'b0, ep.r0} + {1'b0, ep.r1, 1'b0});
        third_g1 = div3({2'b0, ep.g0} + {1'b0, ep.g1, 1'b0});
        third_b1 = div3({2'b0, ep.b0} + {1'b0, ep.b1, 1'b0});
        sum_r = {1'b0, ep.r0} + {1'b0, ep.r1};
        sum_g = {1'b0, ep.g0} + {1'b0, ep.g1};
        sum_b = {1'b0, ep.b0} + {1'b0, ep.b1};

        pal[0] = {8'hFF, ep.b0, ep.g0, ep.r0};
        pal[1] = {8'hFF, ep.b1, ep.g1, ep.r1};
        if (ep.four_colour)
        begin
            pal[2] = {8'hFF, third_b0, third_g0, third_r0};
            pal[3] = {8'hFF, third_b1, third_g1, third_r1};
        end
        else
        begin
            // three colours plus transparent black
            pal[2] = {8'hFF, sum_b[8:1], sum_g[8:1], sum_r[8:1]};
            pal[3] = '0;
        end

        for (int x = 0; x < 4; x++)
        begin
            texels[x] = pal[row_idx[2*x +: 2]];
        end
    end

endmodule

>>> tb/sv/dxt1_row_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dxt1_row_checker
// Watches the block, config and texel-row streams of the DXT1 decoder,
// decodes every accepted block into its four expected texel rows with raster
// tags, and compares each row transfer against the oldest one still due.
// ----------------------------------------------------------------------------
module dxt1_row_checker
#(
    parameter int COUNTER_BITS = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [63:0]                        s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [151:0]                       m_tdata,
    input  logic                               m_tlast,
    input  logic                               m_tuser,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [dxt1_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dxt1_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                 error_count,
    output int                                 rows_pending,
    output int                                 rows_checked,
    output int                                 image_ends
);

    localparam int COUNT_SPAN = 1 << COUNTER_BITS;

    typedef struct packed {
        logic [3:0][31:0] texels;
        logic [1:0]       row_in_block;
        logic [7:0]       block_col;
        logic [7:0]       block_row;
        logic             last_of_block;
        logic             last_of_image;
    } decoded_row_t;

    decoded_row_t rows_due[$];

    logic [dxt1_pkg::CFG_DATA_W-1:0] width_blocks;
    logic [dxt1_pkg::CFG_DATA_W-1:0] height_blocks;
    int                              col_pos;
    int                              row_pos;

    function automatic int wrap_limit(input logic [dxt1_pkg::CFG_DATA_W-1:0] size);
        if (size == 0 || size > COUNT_SPAN)
            return COUNT_SPAN;
        return int'(size);
    endfunction

    function automatic int widen5(input logic [4:0] v);
        return (int'(v) * 255) / 31;
    endfunction

    function automatic int widen6(input logic [5:0] v);
        return (int'(v) * 255) / 63;
    endfunction

    function automatic logic [31:0] rgba(input int r, input int g, input int b, input int a);
        return {a[7:0], b[7:0], g[7:0], r[7:0]};
    endfunction

    // four palette entries, then one row per four index pairs
    task automatic decode_block(input logic [63:0] blk);
        logic [15:0]      c0;
        logic [15:0]      c1;
        logic [31:0]      sel_bits;
        logic [3:0][31:0] palette;
        int               r0, g0, b0, r1, g1, b1;
        bit               col_last;
        bit               row_last;
        decoded_row_t     row;
        c0       = blk[15:0];
        c1       = blk[31:16];
        sel_bits = blk[63:32];
        r0 = widen5(c0[15:11]);
        g0 = widen6(c0[10:5]);
        b0 = widen5(c0[4:0]);
        r1 = widen5(c1[15:11]);
        g1 = widen6(c1[10:5]);
        b1 = widen5(c1[4:0]);
        palette[0] = rgba(r0, g0, b0, 255);
        palette[1] = rgba(r1, g1, b1, 255);
        if (c0 > c1)
        begin
            palette[2] = rgba((2*r0 + r1) / 3, (2*g0 + g1) / 3, (2*b0 + b1) / 3, 255);
            palette[3] = rgba((r0 + 2*r1) / 3, (g0 + 2*g1) / 3, (b0 + 2*b1) / 3, 255);
        end
        else
        begin
            palette[2] = rgba((r0 + r1) / 2, (g0 + g1) / 2, (b0 + b1) / 2, 255);
            palette[3] = '0;
        end
        // a counter at or past a lowered size also counts as the last one
        col_last = (col_pos + 1) >= wrap_limit(width_blocks);
        row_last = (row_pos + 1) >= wrap_limit(height_blocks);
        for (int y = 0; y < 4; y++)
        begin
            for (int x = 0; x < 4; x++)
                row.texels[x] = palette[sel_bits[2*(4*y + x) +: 2]];
            row.row_in_block  = y[1:0];
            row.block_col     = col_pos[7:0];
            row.block_row     = row_pos[7:0];
            row.last_of_block = (y == 3);
            row.last_of_image = (y == 3) && col_last && row_last;
            rows_due.push_back(row);
        end
        if (col_last)
        begin
            col_pos = 0;
            row_pos = row_last ? 0 : (row_pos + 1) % COUNT_SPAN;
        end
        else
            col_pos = (col_pos + 1) % COUNT_SPAN;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            if (error_count < 10)
                $display("mismatch on %s, row transfer %0d: expected %h, got %h",
                         what, rows_checked, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_row_t want;
        if (!rst_n)
        begin
            rows_due.delete();
            width_blocks  = dxt1_pkg::WIDTH_RESET;
            height_blocks = dxt1_pkg::HEIGHT_RESET;
            col_pos       = 0;
            row_pos       = 0;
            error_count   = 0;
            rows_checked  = 0;
            image_ends    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == dxt1_pkg::REG_WIDTH)
                    width_blocks = cfg_data;
                else if (cfg_index == dxt1_pkg::REG_HEIGHT)
                    height_blocks = cfg_data;
            end
            if (s_tvalid && s_tready)
                decode_block(s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (rows_due.size() == 0)
                begin
                    if (error_count < 10)
                        $display("unexpected row transfer: tdata %h tlast %b tuser %b",
                                 m_tdata, m_tlast, m_tuser);
                    error_count++;
                end
                else
                begin
                    want = rows_due.pop_front();
                    check_field("texel_a", m_tdata[31:0], want.texels[0]);
                    check_field("texel_b", m_tdata[63:32], want.texels[1]);
                    check_field("texel_c", m_tdata[95:64], want.texels[2]);
                    check_field("texel_d", m_tdata[127:96], want.texels[3]);
                    check_field("row_in_block", 32'(m_tdata[129:128]), 32'(want.row_in_block));
                    check_field("block_col", 32'(m_tdata[137:130]), 32'(want.block_col));
                    check_field("block_row", 32'(m_tdata[145:138]), 32'(want.block_row));
                    check_field("last_of_block", 32'(m_tlast), 32'(want.last_of_block));
                    check_field("last_of_image", 32'(m_tuser), 32'(want.last_of_image));
                end
                rows_checked++;
                if (m_tuser)
                    image_ends++;
            end
        end
        rows_pending = rows_due.size();
    end

endmodule

>>> tb/sv/tb_dxt1_block_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dxt1_block_decoder_top
// Drives DXT1 blocks and register writes into the decoder under changing
// stall patterns on both streams; a checker alongside predicts and compares
// every texel row, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dxt1_block_decoder_top;

    localparam int WATCHDOG_LIMIT = 4000;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    logic [63:0]                       s_tdata = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    logic [151:0]                      m_tdata;
    logic                              m_tlast;
    logic                              m_tuser;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [dxt1_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [dxt1_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

    int error_count;
    int rows_pending;
    int rows_checked;
    int image_ends;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int blocks_sent = 0;
    int quiet_cycles = 0;

    dxt1_block_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dxt1_row_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .rows_pending (rows_pending),
        .rows_checked (rows_checked),
        .image_ends   (image_ends)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= dst_idle_pct);

    // ends the run if no transfer of any kind happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_dxt1_block_decoder_top failed");
            $finish;
        end
    end

    // leaves s_tvalid high so back-to-back blocks see no gap
    task automatic send_block(input logic [63:0] blk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = blk;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        blocks_sent++;
    endtask

    function automatic logic [63:0] random_block();
        logic [63:0] blk;
        blk = {$urandom, $urandom};
        // equal endpoints now and then, three-colour mode with no order
        if ($urandom_range(7) == 0)
            blk[31:16] = blk[15:0];
        return blk;
    endfunction

    task automatic send_random(input int count);
        repeat (count)
            send_block(random_block());
    endtask

    // sender holds off until every predicted row has gone out
    task automatic drain();
        s_tvalid = 1'b0;
        while (rows_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [dxt1_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dxt1_pkg::CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_size(input logic [dxt1_pkg::CFG_DATA_W-1:0] w,
                            input logic [dxt1_pkg::CFG_DATA_W-1:0] h);
        drain();
        write_reg(dxt1_pkg::REG_WIDTH, w);
        write_reg(dxt1_pkg::REG_HEIGHT, h);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct = 8;
        dst_idle_pct = 88;
        // endpoint extremes, both palette modes, every index in each mode
        send_block(64'h0000_0000_0000_0000);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h0000_0000_0000_FFFF);
        send_block(64'h5555_5555_0000_FFFF);
        send_block(64'hAAAA_AAAA_0000_FFFF);
        send_block(64'hFFFF_FFFF_0000_FFFF);
        send_block(64'hE4E4_E4E4_FFFF_0000);
        send_block(64'hFFFF_FFFF_FFFF_0000);
        send_block(64'h1B1B_1B1B_F81F_07E0);
        send_block(64'hE4E4_E4E4_07E0_F81F);
        send_block(64'h39C6_A55A_1234_1235);
        send_block(64'hC639_5AA5_8410_8410);

        set_size(9'd1, 9'd1);
        send_random(8);

        src_idle_pct = 88;
        dst_idle_pct = 8;
        repeat (4)
        begin
            set_size(9'($urandom_range(1, 6)), 9'($urandom_range(1, 4)));
            // writes to unused indexes must leave the sizes alone
            write_reg(8'($urandom_range(2, 255)), 9'($urandom));
            send_random(10);
        end

        // push both counters up, then shrink the sizes below them
        set_size(9'd1, 9'd0);
        send_random(5);
        set_size(9'd511, 9'd0);
        send_random(7);
        set_size(9'd3, 9'd2);
        send_random(8);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        // full-range column wrap
        set_size(9'd256, 9'd2);
        send_random(260);
        drain();
        write_reg(8'hFF, 9'h1FF);
        set_size(9'($urandom_range(1, 8)), 9'($urandom_range(1, 3)));
        send_random(12);

        drain();
        repeat (8) @(negedge clk);
        $display("%0d blocks decoded into %0d checked rows, %0d image ends seen,",
                 blocks_sent, rows_checked, image_ends);
        $display("sizes from 1x1 to the full counter range, with shrink and wrap cases");
        if (error_count == 0 && rows_pending == 0)
            $display("tb_dxt1_block_decoder_top passed");
        else
        begin
            $display("%0d mismatches, %0d rows never arrived", error_count, rows_pending);
            $display("tb_dxt1_block_decoder_top failed");
        end
        $finish;
    end

endmodule
